/* rtl/core/arq_retransmit_tracker_assert.svh */
// Assertion helpers for the retransmit tracker.
`ifndef ARQ_RETRANSMIT_TRACKER_ASSERT_SVH
`define ARQ_RETRANSMIT_TRACKER_ASSERT_SVH

// Checked property on the rising clock edge, ignored while reset is active.
`define ARQ_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("arq_retransmit_tracker: assertion failed");

// Checked property on the rising clock edge, also during reset.
`define ARQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("arq_retransmit_tracker: assertion failed");

`endif

/* rtl/core/arq_pkg.sv */
`default_nettype none

package arq_pkg;

  // Field widths.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ID_W    = 31;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TO_W    = 8;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  // Default table depth and timeout reset value.
  localparam int unsigned TABLE_ENTRIES_DEF = 32;
  localparam logic [TO_W-1:0] TIMEOUT_RST = 8'd2;

  // Register word index of the timeout register.
  localparam logic REG_TIMEOUT = 1'b0;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SEND = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_MSG  = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] K_SENT         = 4'd0;
  localparam logic [KIND_W-1:0] K_REFUSED      = 4'd1;
  localparam logic [KIND_W-1:0] K_ACK_OK       = 4'd2;
  localparam logic [KIND_W-1:0] K_ACK_UNKNOWN  = 4'd3;
  localparam logic [KIND_W-1:0] K_ACCEPT_ACK   = 4'd4;
  localparam logic [KIND_W-1:0] K_DUP_ACK      = 4'd5;
  localparam logic [KIND_W-1:0] K_ACCEPT_NOACK = 4'd6;
  localparam logic [KIND_W-1:0] K_RETX         = 4'd7;
  localparam logic [KIND_W-1:0] K_IDLE         = 4'd8;

endpackage

`default_nettype wire

/* rtl/core/arq_retransmit_tracker.sv */
`default_nettype none

// Selective-repeat ARQ bookkeeping. An operation is taken when start_i is high
// and busy_o is low. busy_o then stays high while the pending and seen tables,
// which sit in synchronous memories with one write port and one registered
// read port, are swept one slot per cycle, then while the last slot is checked
// and the operation finishes. The next operation is taken at the end of an
// idle cycle, so a new operation is never taken before the last one is done.
// Results appear on kind_o, out_id_o and last_o for a single cycle, marked by
// result_valid_o, and cannot be stalled by the receiver. Send, acknowledgement
// and message operations give exactly one result, in the cycle in which busy_o
// falls; a tick gives one retransmit result per due slot in slot order, spread
// over the sweep, or one idle result, and last_o marks the final result of the
// operation. The timeout register is written through the APB port; the user
// must write it only while the block is idle, as the block does not enforce it.
module arq_retransmit_tracker #(
  parameter int unsigned TABLE_ENTRIES = arq_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Command channel.
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [arq_pkg::OP_W-1:0]    op_i,
  input  wire logic [arq_pkg::ID_W-1:0]    msg_id_i,
  // Result channel.
  output logic                             result_valid_o,
  output logic [arq_pkg::KIND_W-1:0]       kind_o,
  output logic [arq_pkg::ID_W-1:0]         out_id_o,
  output logic                             last_o,
  // Configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [arq_pkg::APB_AW-1:0]  paddr,
  input  wire logic [arq_pkg::APB_DW-1:0]  pwdata,
  output logic [arq_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  localparam int unsigned IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned PendW = arq_pkg::ID_W + arq_pkg::TIME_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [arq_pkg::OP_W-1:0]      op_q, op_d;
  logic [arq_pkg::ID_W-1:0]      id_q, id_d;
  logic [IdxW-1:0]               idx_q, idx_d;
  logic                          chk_v_q, chk_v_d;
  logic [IdxW-1:0]               chk_idx_q, chk_idx_d;
  logic                          hit_q, hit_d;
  logic [IdxW-1:0]               hit_slot_q, hit_slot_d;
  logic                          free_q, free_d;
  logic [IdxW-1:0]               free_slot_q, free_slot_d;
  logic                          prev_v_q, prev_v_d;
  logic [arq_pkg::ID_W-1:0]      prev_id_q, prev_id_d;
  logic [arq_pkg::TIME_W-1:0]    now_q, now_d;
  logic [arq_pkg::ID_W-1:0]      next_id_q, next_id_d;
  logic [arq_pkg::TO_W-1:0]      timeout_q, timeout_d;
  logic [TABLE_ENTRIES-1:0]      pv_q, pv_d;
  logic [TABLE_ENTRIES-1:0]      sv_q, sv_d;
  logic                          res_v_q, res_v_d;
  logic [arq_pkg::KIND_W-1:0]    kind_q, kind_d;
  logic [arq_pkg::ID_W-1:0]      res_id_q, res_id_d;
  logic                          last_q, last_d;

  // Table memories: pending holds {id, stamp}, seen holds the id.
  logic [PendW-1:0]              pend_mem [TABLE_ENTRIES];
  logic [arq_pkg::ID_W-1:0]      seen_mem [TABLE_ENTRIES];
  logic [PendW-1:0]              pend_rd_q;
  logic [arq_pkg::ID_W-1:0]      seen_rd_q;

  logic                          pend_we;
  logic [IdxW-1:0]               pend_wa;
  logic [PendW-1:0]              pend_wd;
  logic                          seen_we;

  logic                          accept;
  logic                          cfg_wr;
  logic [arq_pkg::ID_W-1:0]      rd_id;
  logic [arq_pkg::TIME_W-1:0]    rd_stamp;
  logic [arq_pkg::TIME_W-1:0]    age;
  logic                          due;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign rd_id    = pend_rd_q[PendW-1:arq_pkg::TIME_W];
  assign rd_stamp = pend_rd_q[arq_pkg::TIME_W-1:0];
  assign age      = now_q - rd_stamp;

  // A pending slot is due on a tick once its age reaches the timeout.
  assign due = chk_v_q && (op_q == arq_pkg::OP_TICK) && pv_q[chk_idx_q] &&
               (age >= {{(arq_pkg::TIME_W - arq_pkg::TO_W){1'b0}}, timeout_q});

  // Pending memory write: restamp a due slot, or store a new send.
  // The sweep only writes slots it has already read, so no forwarding is needed.
  always_comb begin
    pend_we = 1'b0;
    pend_wa = chk_idx_q;
    pend_wd = {rd_id, now_q};
    if (due) begin
      pend_we = 1'b1;
    end else if ((state_q == ST_FIN) && (op_q == arq_pkg::OP_SEND) && hit_q) begin
      pend_we = 1'b1;
      pend_wa = hit_slot_q;
      pend_wd = {next_id_q, now_q};
    end
  end

  assign seen_we = (state_q == ST_FIN) && (op_q == arq_pkg::OP_MSG) && !hit_q && free_q;

  // Memories with a registered read port at the sweep index.
  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    if (seen_we) begin
      seen_mem[free_slot_q] <= id_q;
    end
    pend_rd_q <= pend_mem[idx_q];
    seen_rd_q <= seen_mem[idx_q];
  end

  // Sequencer, slot checks and result generation.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    id_d        = id_q;
    idx_d       = idx_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = idx_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    free_d      = free_q;
    free_slot_d = free_slot_q;
    prev_v_d    = prev_v_q;
    prev_id_d   = prev_id_q;
    now_d       = now_q;
    next_id_d   = next_id_q;
    timeout_d   = timeout_q;
    pv_d        = pv_q;
    sv_d        = sv_q;
    res_v_d     = 1'b0;
    kind_d      = kind_q;
    res_id_d    = res_id_q;
    last_d      = last_q;

    // Configuration write.
    if (cfg_wr && (paddr[2] == arq_pkg::REG_TIMEOUT)) begin
      timeout_d = pwdata[arq_pkg::TO_W-1:0];
    end

    // Check the slot whose memory data has just come back.
    if (chk_v_q) begin
      unique case (op_q)
        arq_pkg::OP_SEND: begin
          if (!hit_q && !pv_q[chk_idx_q]) begin
            hit_d      = 1'b1;
            hit_slot_d = chk_idx_q;
          end
        end
        arq_pkg::OP_ACK: begin
          if (!hit_q && pv_q[chk_idx_q] && (rd_id == id_q)) begin
            hit_d      = 1'b1;
            hit_slot_d = chk_idx_q;
          end
        end
        arq_pkg::OP_MSG: begin
          if (sv_q[chk_idx_q] && (seen_rd_q == id_q)) begin
            hit_d = 1'b1;
          end
          if (!free_q && !sv_q[chk_idx_q]) begin
            free_d      = 1'b1;
            free_slot_d = chk_idx_q;
          end
        end
        arq_pkg::OP_TICK: begin
          // Hold each retransmit back one find so the final one can carry last.
          if (due) begin
            if (prev_v_q) begin
              res_v_d  = 1'b1;
              kind_d   = arq_pkg::K_RETX;
              res_id_d = prev_id_q;
              last_d   = 1'b0;
            end
            prev_v_d  = 1'b1;
            prev_id_d = rd_id;
          end
        end
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d  = ST_SCAN;
          op_d     = op_i;
          id_d     = msg_id_i;
          idx_d    = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          prev_v_d = 1'b0;
          if (op_i == arq_pkg::OP_SEND) begin
            next_id_d = next_id_q + 1'b1;
          end
          if (op_i == arq_pkg::OP_TICK) begin
            now_d = now_q + 1'b1;
          end
        end
      end
      ST_SCAN: begin
        chk_v_d   = 1'b1;
        chk_idx_d = idx_q;
        if (idx_q == IdxW'(TABLE_ENTRIES - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        state_d = ST_IDLE;
        res_v_d = 1'b1;
        last_d  = 1'b1;
        unique case (op_q)
          arq_pkg::OP_SEND: begin
            res_id_d = next_id_q;
            if (hit_q) begin
              kind_d           = arq_pkg::K_SENT;
              pv_d[hit_slot_q] = 1'b1;
            end else begin
              kind_d = arq_pkg::K_REFUSED;
            end
          end
          arq_pkg::OP_ACK: begin
            res_id_d = id_q;
            if (hit_q) begin
              kind_d           = arq_pkg::K_ACK_OK;
              pv_d[hit_slot_q] = 1'b0;
            end else begin
              kind_d = arq_pkg::K_ACK_UNKNOWN;
            end
          end
          arq_pkg::OP_MSG: begin
            res_id_d = id_q;
            if (hit_q) begin
              kind_d = arq_pkg::K_DUP_ACK;
            end else if (free_q) begin
              kind_d            = arq_pkg::K_ACCEPT_ACK;
              sv_d[free_slot_q] = 1'b1;
            end else begin
              kind_d = arq_pkg::K_ACCEPT_NOACK;
            end
          end
          arq_pkg::OP_TICK: begin
            if (prev_v_q) begin
              kind_d   = arq_pkg::K_RETX;
              res_id_d = prev_id_q;
            end else begin
              kind_d   = arq_pkg::K_IDLE;
              res_id_d = '0;
            end
          end
          default: ;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers with asynchronous reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chk_v_q   <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      prev_v_q  <= 1'b0;
      now_q     <= '0;
      next_id_q <= '0;
      timeout_q <= arq_pkg::TIMEOUT_RST;
      pv_q      <= '0;
      sv_q      <= '0;
      res_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_v_q   <= chk_v_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      prev_v_q  <= prev_v_d;
      now_q     <= now_d;
      next_id_q <= next_id_d;
      timeout_q <= timeout_d;
      pv_q      <= pv_d;
      sv_q      <= sv_d;
      res_v_q   <= res_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    id_q        <= id_d;
    idx_q       <= idx_d;
    chk_idx_q   <= chk_idx_d;
    hit_slot_q  <= hit_slot_d;
    free_slot_q <= free_slot_d;
    prev_id_q   <= prev_id_d;
    kind_q      <= kind_d;
    res_id_q    <= res_id_d;
    last_q      <= last_d;
  end

  // Outputs.
  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_v_q;
  assign kind_o         = kind_q;
  assign out_id_o       = res_id_q;
  assign last_o         = last_q;
  assign pready         = 1'b1;
  assign prdata         = (paddr[2] == arq_pkg::REG_TIMEOUT) ?
                          {{(arq_pkg::APB_DW - arq_pkg::TO_W){1'b0}}, timeout_q} : '0;

`include "arq_retransmit_tracker_assert.svh"

  // An accepted operation always starts the table sweep.
  `ARQ_ASSERT_RST(a_accept_scan, clk_i, rst_ni, accept |=> (state_q == ST_SCAN))

  // The final result of an operation coincides with the return to idle.
  `ARQ_ASSERT_RST(a_last_idle, clk_i, rst_ni, (res_v_q && last_q) |-> (state_q == ST_IDLE))

  // Results that are not final only come from a tick sweep.
  `ARQ_ASSERT_RST(a_mid_tick, clk_i, rst_ni,
                  (res_v_q && !last_q) |-> (busy_o && (op_q == arq_pkg::OP_TICK)))

  // A cycle spent in reset is never followed by a result strobe.
  `ARQ_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !result_valid_o)

endmodule

`default_nettype wire

/* verif/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES      = arq_pkg::TABLE_ENTRIES_DEF;
  localparam int unsigned SETTLE_TICKS = ENTRIES + 8;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 50;

  // Traffic mixes for the random phases.
  localparam int MIX_FILL    = 0;
  localparam int MIX_EVEN    = 1;
  localparam int MIX_RELEASE = 2;

  typedef enum logic [2:0] {
    DRV_IDLE,
    DRV_CMD,
    DRV_SETTLE,
    DRV_SETUP,
    DRV_ACCESS,
    DRV_DONE
  } drv_state_e;

  // One queued command or timeout write.
  typedef struct {
    logic                          is_cfg;
    logic [arq_pkg::OP_W-1:0]      op;
    logic [arq_pkg::ID_W-1:0]      id;
    logic [arq_pkg::TO_W-1:0]      timeout;
  } stim_t;

  // One expected tracker event.
  typedef struct {
    logic [arq_pkg::KIND_W-1:0]    kind;
    logic [arq_pkg::ID_W-1:0]      id;
    logic                          last;
  } event_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start_i = 1'b0;
  logic [arq_pkg::OP_W-1:0]        op_i = arq_pkg::OP_TICK;
  logic [arq_pkg::ID_W-1:0]        msg_id_i = '0;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [arq_pkg::APB_AW-1:0]      paddr = '0;
  logic [arq_pkg::APB_DW-1:0]      pwdata = '0;
  logic                            busy_o;
  logic                            result_valid_o;
  logic [arq_pkg::KIND_W-1:0]      kind_o;
  logic [arq_pkg::ID_W-1:0]        out_id_o;
  logic                            last_o;
  logic [arq_pkg::APB_DW-1:0]      prdata;
  logic                            pready;

  arq_retransmit_tracker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .msg_id_i       (msg_id_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .out_id_o       (out_id_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the tracker state.
  logic                            pend_valid [ENTRIES];
  logic [arq_pkg::ID_W-1:0]        pend_id    [ENTRIES];
  logic [arq_pkg::TIME_W-1:0]      pend_stamp [ENTRIES];
  logic                            seen_valid [ENTRIES];
  logic [arq_pkg::ID_W-1:0]        seen_id    [ENTRIES];
  logic [arq_pkg::ID_W-1:0]        id_counter;
  logic [arq_pkg::TIME_W-1:0]      now_ticks;
  logic [arq_pkg::TO_W-1:0]        timeout_ticks;

  stim_t               cmd_q [$];
  event_t              event_q [$];
  drv_state_e          drv_state = DRV_IDLE;
  stim_t               cur;
  event_t              got;
  event_t              want;
  int unsigned         gap_left = 0;
  int unsigned         settle_left = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         mismatches = 0;
  int unsigned         cmds_done = 0;
  int unsigned         events_done = 0;
  int unsigned         cfg_writes = 0;
  int unsigned         kind_seen [16];
  int unsigned         ids_issued = 0;

  // Mismatch bookkeeping: only the first few are printed.
  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  task automatic expect_event(input logic [arq_pkg::KIND_W-1:0] kind,
                              input logic [arq_pkg::ID_W-1:0] id,
                              input logic last);
    event_t e;
    e.kind = kind;
    e.id   = id;
    e.last = last;
    event_q.push_back(e);
    kind_seen[kind]++;
  endtask

  // Apply one accepted command to the shadow state and queue its events.
  task automatic track_command(input logic [arq_pkg::OP_W-1:0] op,
                               input logic [arq_pkg::ID_W-1:0] id);
    int                          slot;
    int unsigned                 n_retx;
    logic [arq_pkg::TIME_W-1:0]  age;
    slot = -1;
    n_retx = 0;
    case (op)
      arq_pkg::OP_SEND: begin
        id_counter = id_counter + 1'b1;
        for (int s = 0; s < ENTRIES; s++) begin
          if (slot < 0 && !pend_valid[s]) slot = s;
        end
        if (slot >= 0) begin
          pend_valid[slot] = 1'b1;
          pend_id[slot]    = id_counter;
          pend_stamp[slot] = now_ticks;
          expect_event(arq_pkg::K_SENT, id_counter, 1'b1);
        end else begin
          expect_event(arq_pkg::K_REFUSED, id_counter, 1'b1);
        end
      end
      arq_pkg::OP_ACK: begin
        for (int s = 0; s < ENTRIES; s++) begin
          if (slot < 0 && pend_valid[s] && pend_id[s] == id) slot = s;
        end
        if (slot >= 0) begin
          pend_valid[slot] = 1'b0;
          expect_event(arq_pkg::K_ACK_OK, id, 1'b1);
        end else begin
          expect_event(arq_pkg::K_ACK_UNKNOWN, id, 1'b1);
        end
      end
      arq_pkg::OP_MSG: begin
        for (int s = 0; s < ENTRIES; s++) begin
          if (slot < 0 && seen_valid[s] && seen_id[s] == id) slot = s;
        end
        if (slot >= 0) begin
          expect_event(arq_pkg::K_DUP_ACK, id, 1'b1);
        end else begin
          for (int s = 0; s < ENTRIES; s++) begin
            if (slot < 0 && !seen_valid[s]) slot = s;
          end
          if (slot >= 0) begin
            seen_valid[slot] = 1'b1;
            seen_id[slot]    = id;
            expect_event(arq_pkg::K_ACCEPT_ACK, id, 1'b1);
          end else begin
            expect_event(arq_pkg::K_ACCEPT_NOACK, id, 1'b1);
          end
        end
      end
      default: begin
        // Tick: age is taken after time advances, modulo the time width.
        now_ticks = now_ticks + 1'b1;
        for (int s = 0; s < ENTRIES; s++) begin
          age = now_ticks - pend_stamp[s];
          if (pend_valid[s] && age >= arq_pkg::TIME_W'(timeout_ticks)) begin
            pend_stamp[s] = now_ticks;
            expect_event(arq_pkg::K_RETX, pend_id[s], 1'b0);
            n_retx++;
          end
        end
        if (n_retx == 0) begin
          expect_event(arq_pkg::K_IDLE, '0, 1'b1);
        end else begin
          event_q[event_q.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(4, 1);
    return $urandom_range(80, 20);
  endfunction

  task automatic add_cmd(input logic [arq_pkg::OP_W-1:0] op,
                         input logic [arq_pkg::ID_W-1:0] id);
    stim_t s;
    s.is_cfg  = 1'b0;
    s.op      = op;
    s.id      = id;
    s.timeout = '0;
    cmd_q.push_back(s);
    if (op == arq_pkg::OP_SEND) ids_issued++;
  endtask

  task automatic add_timeout_write(input logic [arq_pkg::TO_W-1:0] value);
    stim_t s;
    s.is_cfg  = 1'b1;
    s.op      = arq_pkg::OP_TICK;
    s.id      = '0;
    s.timeout = value;
    cmd_q.push_back(s);
  endtask

  // Random command: acks mostly target recently issued ids, messages mostly
  // come from a small pool so that duplicates and a full seen list happen.
  task automatic add_random_cmd(input int mix);
    int unsigned                 r;
    int unsigned                 lo;
    int unsigned                 hi;
    logic [arq_pkg::OP_W-1:0]    op;
    logic [arq_pkg::ID_W-1:0]    id;
    r  = $urandom_range(99, 0);
    id = arq_pkg::ID_W'($urandom());
    case (mix)
      MIX_FILL: begin
        op = (r < 65) ? arq_pkg::OP_SEND : (r < 70) ? arq_pkg::OP_ACK :
             (r < 85) ? arq_pkg::OP_MSG : arq_pkg::OP_TICK;
      end
      MIX_RELEASE: begin
        op = (r < 10) ? arq_pkg::OP_SEND : (r < 60) ? arq_pkg::OP_ACK :
             (r < 75) ? arq_pkg::OP_MSG : arq_pkg::OP_TICK;
      end
      default: begin
        op = (r < 25) ? arq_pkg::OP_SEND : (r < 50) ? arq_pkg::OP_ACK :
             (r < 75) ? arq_pkg::OP_MSG : arq_pkg::OP_TICK;
      end
    endcase
    r = $urandom_range(99, 0);
    if (op == arq_pkg::OP_ACK && r < 80) begin
      hi = (ids_issued > 0) ? ids_issued : 1;
      lo = (ids_issued > 48) ? ids_issued - 48 : 1;
      id = arq_pkg::ID_W'($urandom_range(hi, lo));
    end else if (op == arq_pkg::OP_MSG) begin
      if (r < 50) id = arq_pkg::ID_W'($urandom_range(60, 0));
      else if (r < 70) id = {arq_pkg::ID_W{1'b1}} - arq_pkg::ID_W'($urandom_range(7, 0));
    end
    add_cmd(op, id);
  endtask

  // Driver: commands are held until accepted, timeout writes wait for an
  // idle tracker and then take an APB setup and access cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      case (drv_state)
        DRV_IDLE: begin
          if (gap_left != 0) begin
            gap_left = gap_left - 1;
          end else if (cmd_q.size() == 0) begin
            drv_state <= DRV_DONE;
          end else if (cmd_q[0].is_cfg) begin
            settle_left <= SETTLE_TICKS;
            drv_state   <= DRV_SETTLE;
          end else begin
            cur = cmd_q.pop_front();
            start_i   <= 1'b1;
            op_i      <= cur.op;
            msg_id_i  <= cur.id;
            drv_state <= DRV_CMD;
          end
        end
        DRV_CMD: begin
          if (start_i && !busy_o) begin
            track_command(op_i, msg_id_i);
            cmds_done++;
            gap_left = pick_gap();
            if (gap_left == 0 && cmd_q.size() != 0 && !cmd_q[0].is_cfg) begin
              cur = cmd_q.pop_front();
              op_i     <= cur.op;
              msg_id_i <= cur.id;
            end else begin
              start_i   <= 1'b0;
              drv_state <= DRV_IDLE;
            end
          end
        end
        DRV_SETTLE: begin
          if (event_q.size() != 0 || busy_o) begin
            settle_left <= SETTLE_TICKS;
          end else if (settle_left != 0) begin
            settle_left <= settle_left - 1;
          end else begin
            cur = cmd_q.pop_front();
            psel      <= 1'b1;
            penable   <= 1'b0;
            pwrite    <= 1'b1;
            paddr     <= {arq_pkg::REG_TIMEOUT, 2'b00};
            pwdata    <= arq_pkg::APB_DW'(cur.timeout);
            drv_state <= DRV_SETUP;
          end
        end
        DRV_SETUP: begin
          penable   <= 1'b1;
          drv_state <= DRV_ACCESS;
        end
        DRV_ACCESS: begin
          if (psel && penable && pwrite && pready) begin
            timeout_ticks = pwdata[arq_pkg::TO_W-1:0];
            cfg_writes++;
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            drv_state <= DRV_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Monitor: every strobed event is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        events_done++;
        got.kind = kind_o;
        got.id   = out_id_o;
        got.last = last_o;
        if (event_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected event kind=%0d id=%0d last=%0b",
                                  got.kind, got.id, got.last));
        end else begin
          want = event_q.pop_front();
          if (got.kind !== want.kind || got.id !== want.id || got.last !== want.last) begin
            flag_mismatch($sformatf({"event mismatch: expected kind=%0d id=%0d last=%0b,",
                                     " got kind=%0d id=%0d last=%0b"},
                                    want.kind, want.id, want.last,
                                    got.kind, got.id, got.last));
          end
        end
      end
      if (result_valid_o || (start_i && !busy_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog on a stalled transaction flow.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("arq_retransmit_tracker: mismatch");
    $finish;
  end

  initial begin
    // Shadow state after reset.
    for (int s = 0; s < ENTRIES; s++) begin
      pend_valid[s] = 1'b0;
      pend_id[s]    = '0;
      pend_stamp[s] = '0;
      seen_valid[s] = 1'b0;
      seen_id[s]    = '0;
    end
    for (int k = 0; k < 16; k++) kind_seen[k] = 0;
    id_counter    = '0;
    now_ticks     = '0;
    timeout_ticks = arq_pkg::TIMEOUT_RST;

    // Directed opening: idle tick, unknown acks at the id extremes, new and
    // duplicate messages, retransmit timing, a zero timeout and ack matching.
    add_cmd(arq_pkg::OP_TICK, '0);
    add_cmd(arq_pkg::OP_ACK, '0);
    add_cmd(arq_pkg::OP_ACK, {arq_pkg::ID_W{1'b1}});
    add_cmd(arq_pkg::OP_MSG, '0);
    add_cmd(arq_pkg::OP_MSG, {arq_pkg::ID_W{1'b1}});
    add_cmd(arq_pkg::OP_MSG, '0);
    add_cmd(arq_pkg::OP_SEND, {arq_pkg::ID_W{1'b1}});
    add_cmd(arq_pkg::OP_SEND, '0);
    add_cmd(arq_pkg::OP_TICK, {arq_pkg::ID_W{1'b1}});
    add_cmd(arq_pkg::OP_TICK, '0);
    add_cmd(arq_pkg::OP_ACK, arq_pkg::ID_W'(1));
    add_cmd(arq_pkg::OP_ACK, arq_pkg::ID_W'(1));
    add_cmd(arq_pkg::OP_TICK, '0);
    add_cmd(arq_pkg::OP_TICK, '0);
    add_timeout_write('0);
    add_cmd(arq_pkg::OP_TICK, '0);
    add_cmd(arq_pkg::OP_TICK, '0);
    add_timeout_write(arq_pkg::TO_W'(1));
    add_cmd(arq_pkg::OP_SEND, '0);
    add_cmd(arq_pkg::OP_TICK, '0);
    add_cmd(arq_pkg::OP_ACK, arq_pkg::ID_W'(2));
    add_cmd(arq_pkg::OP_ACK, arq_pkg::ID_W'(3));

    // Random phases, each with its own timeout and traffic mix.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: add_timeout_write({arq_pkg::TO_W{1'b1}});
        1: add_timeout_write(arq_pkg::TO_W'(1));
        2: add_timeout_write('0);
        3: add_timeout_write(arq_pkg::TO_W'($urandom_range(255, 1)));
        4: add_timeout_write(arq_pkg::TO_W'(3));
        default: add_timeout_write(arq_pkg::TO_W'($urandom_range(255, 1)));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        add_random_cmd((p == 0 || p == 4) ? MIX_FILL :
                       (p == 2 || p == 5) ? MIX_RELEASE : MIX_EVEN);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(drv_state == DRV_DONE && event_q.size() == 0)) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);

    if (event_q.size() != 0) begin
      flag_mismatch($sformatf("%0d predicted events never arrived", event_q.size()));
    end

    $display("Ran %0d commands and %0d timeout writes; checked %0d events, %0d mismatches.",
             cmds_done, cfg_writes, events_done, mismatches);
    $display("Seen: %0d refused sends, %0d retransmits, %0d duplicates, %0d unacked deliveries.",
             kind_seen[arq_pkg::K_REFUSED], kind_seen[arq_pkg::K_RETX],
             kind_seen[arq_pkg::K_DUP_ACK], kind_seen[arq_pkg::K_ACCEPT_NOACK]);
    if (mismatches == 0) begin
      $display("arq_retransmit_tracker: match");
    end else begin
      $display("arq_retransmit_tracker: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
